@@ design/ffps_pkg.sv @@
// Shared types, constants and helpers for the flow field particle step block.
// No dependencies; used by every other file of the block.
package ffps_pkg;

    localparam int GRID_ROWS_DEF = 32;
    localparam int GRID_COLS_DEF = 32;
    localparam int TABLE_DEPTH   = 1024;
    localparam int TABLE_AW      = 10;
    localparam int TABLE_DW      = 64;
    localparam int PIPE_LAST     = 17;

    localparam logic [24:0] Q360 = 25'd23592960;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    localparam logic [1:0] CFG_AREA_LEFT   = 2'd0;
    localparam logic [1:0] CFG_AREA_TOP    = 2'd1;
    localparam logic [1:0] CFG_AREA_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_AREA_HEIGHT = 2'd3;

    localparam logic signed [31:0] AREA_LEFT_RST   = 32'sd0;
    localparam logic signed [31:0] AREA_TOP_RST    = 32'sd0;
    localparam logic [30:0]        AREA_WIDTH_RST  = 31'd125829120;
    localparam logic [30:0]        AREA_HEIGHT_RST = 31'd70778880;

    localparam logic [1:0] AMODE_IN  = 2'd0;
    localparam logic [1:0] AMODE_GT  = 2'd1;
    localparam logic [1:0] AMODE_NEG = 2'd2;

    typedef struct packed {
        logic               load;
        logic               dead;
        logic [9:0]         cidx;
        logic signed [31:0] flx;
        logic signed [31:0] fly;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [24:0]        ang;
        logic signed [31:0] spin;
        logic signed [31:0] life;
        logic [30:0]        dt;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [39:0]        rx;
        logic [39:0]        ry;
        logic [7:0]         cx;
        logic [7:0]         cy;
        logic               xlo;
        logic               xhi;
        logic               xz;
        logic               ylo;
        logic               yhi;
        logic               yz;
        logic signed [63:0] aprod;
        logic [1:0]         amode;
        logic [47:0]        am;
        logic signed [64:0] prx;
        logic signed [64:0] pry;
        logic signed [31:0] nvx;
        logic signed [31:0] nvy;
        logic signed [49:0] sx;
        logic signed [49:0] sy;
        logic signed [31:0] npx;
        logic signed [31:0] npy;
    } stage_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return $signed(v[31:0]);
        end
    endfunction

endpackage

@@ design/ffps_flow_mem.sv @@
// Flow vector table: one write port, one registered read port.
// Depends on ffps_pkg for default sizes.
module ffps_flow_mem #(
    parameter int DEPTH = ffps_pkg::TABLE_DEPTH,
    parameter int AW    = ffps_pkg::TABLE_AW,
    parameter int DW    = ffps_pkg::TABLE_DW
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/flow_field_particle_step.sv @@
// Top level of the flow field particle step block: pipeline, config and output.
// Depends on ffps_pkg and ffps_flow_mem.
// The block takes one item per clock while the pipeline is not held, loads and updates mixed
// freely, and each update item returns one result; a load item writes the flow table and
// returns nothing. Loads and table lookups meet the table at the same pipeline stage, so a
// lookup always sees exactly the loads accepted before it. The cell index divider (one
// quotient bit per stage, eight stages) sits ahead of the table lookup, followed by the
// steer, integrate and wrap stages; the angle wrap runs alongside, reducing in three stages.
// The whole pipeline holds only when the output register is full, not taken, and
// another result waits behind it; bubbles still advance. Configure only while idle.
module flow_field_particle_step #(
    parameter int GRID_ROWS = ffps_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = ffps_pkg::GRID_COLS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic [9:0]         s_cell_index,
    input  logic signed [31:0] s_flow_x,
    input  logic signed [31:0] s_flow_y,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic [24:0]        s_angle,
    input  logic signed [31:0] s_spin_rate,
    input  logic signed [31:0] s_life_left,
    input  logic [30:0]        s_time_step,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_new_pos_x,
    output logic signed [31:0] m_new_pos_y,
    output logic signed [31:0] m_new_vel_x,
    output logic signed [31:0] m_new_vel_y,
    output logic [24:0]        m_new_angle,
    output logic signed [31:0] m_new_life,
    output logic               m_alive
);

    localparam int NS = ffps_pkg::PIPE_LAST;

    // Configuration registers
    logic signed [31:0] area_left_reg;
    logic signed [31:0] area_top_reg;
    logic [30:0]        area_width_reg;
    logic [30:0]        area_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            area_left_reg   <= ffps_pkg::AREA_LEFT_RST;
            area_top_reg    <= ffps_pkg::AREA_TOP_RST;
            area_width_reg  <= ffps_pkg::AREA_WIDTH_RST;
            area_height_reg <= ffps_pkg::AREA_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                ffps_pkg::CFG_AREA_LEFT:   area_left_reg   <= $signed(cfg_wdata);
                ffps_pkg::CFG_AREA_TOP:    area_top_reg    <= $signed(cfg_wdata);
                ffps_pkg::CFG_AREA_WIDTH:  area_width_reg  <= cfg_wdata[30:0];
                ffps_pkg::CFG_AREA_HEIGHT: area_height_reg <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // Pipeline stages
    ffps_pkg::stage_t pl_reg [0:NS];
    ffps_pkg::stage_t in_next;
    logic [NS:0]      pl_valid_reg;
    logic             en;
    logic             res_at_end;
    logic             m_valid_reg;
    logic [63:0]      rd_data;

    // Advance unless a result sits at the end and the output cannot take it.
    assign res_at_end = pl_valid_reg[NS] && !pl_reg[NS].load;
    assign en         = !res_at_end || !m_valid_reg || m_ready;
    assign s_ready    = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pl_valid_reg <= '0;
        end else if (en) begin
            pl_valid_reg <= {pl_valid_reg[NS-1:0], s_valid};
        end
    end

    // Capture the item
    always_comb begin
        in_next      = '0;
        in_next.load = (s_req_type == ffps_pkg::REQ_LOAD);
        in_next.dead = (s_life_left <= 32'sd0);
        in_next.cidx = s_cell_index;
        in_next.flx  = s_flow_x;
        in_next.fly  = s_flow_y;
        in_next.px   = s_pos_x;
        in_next.py   = s_pos_y;
        in_next.vx   = s_vel_x;
        in_next.vy   = s_vel_y;
        in_next.ang  = s_angle;
        in_next.spin = s_spin_rate;
        in_next.life = s_life_left;
        in_next.dt   = s_time_step;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg[0] <= in_next;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_st
        // Divider bit for stages 3..10.
        localparam int DB = (k >= 3 && k <= 10) ? 10 - k : 0;

        ffps_pkg::stage_t   nx;
        logic signed [63:0] ashr;
        logic signed [47:0] asum;
        logic signed [49:0] ex;
        logic signed [49:0] ey;
        logic signed [49:0] wx;
        logic signed [49:0] wy;
        logic [39:0]        dvx;
        logic [39:0]        dvy;
        logic [13:0]        af1;
        logic [12:0]        af2;
        logic [12:0]        ax;
        logic [25:0]        aprd;
        logic [7:0]         aq;
        logic [12:0]        ar;

        always_comb begin
            nx   = pl_reg[k-1];
            ashr = pl_reg[k-1].aprod >>> 16;
            asum = $signed({23'd0, pl_reg[k-1].ang}) + $signed(ashr[47:0]);
            ex   = 50'($signed(area_left_reg)) + 50'($signed({1'b0, area_width_reg}));
            ey   = 50'($signed(area_top_reg)) + 50'($signed({1'b0, area_height_reg}));
            wx   = pl_reg[k-1].sx;
            wy   = pl_reg[k-1].sy;
            dvx  = 40'(area_width_reg) << DB;
            dvy  = 40'(area_height_reg) << DB;
            // 360.0 is 45 * 2^19 and 2^12 is 1 modulo 45: fold 12-bit chunks of the
            // upper part, then take the last remainder by reciprocal multiplication.
            af1  = 14'(pl_reg[k-1].am[30:19]) + 14'(pl_reg[k-1].am[42:31]) +
                   14'(pl_reg[k-1].am[47:43]);
            af2  = 13'(pl_reg[k-1].am[30:19]) + 13'(pl_reg[k-1].am[32:31]);
            ax   = pl_reg[k-1].am[31:19];
            aprd = 26'(ax) * 26'd5826;
            aq   = aprd[25:18];
            ar   = ax - 13'(aq) * 13'd45;
            if (k == 1) begin
                // Offset from the area edge; spin times step
                nx.dx    = 33'($signed(pl_reg[k-1].px)) - 33'($signed(area_left_reg));
                nx.dy    = 33'($signed(pl_reg[k-1].py)) - 33'($signed(area_top_reg));
                nx.aprod = 64'($signed(pl_reg[k-1].spin)) *
                           64'($signed({1'b0, pl_reg[k-1].dt}));
            end
            if (k == 2) begin
                // Scale by the grid size, flag the clamped cases
                nx.xlo = pl_reg[k-1].dx[32];
                nx.ylo = pl_reg[k-1].dy[32];
                nx.xz  = (area_width_reg == 31'd0);
                nx.yz  = (area_height_reg == 31'd0);
                nx.xhi = !pl_reg[k-1].dx[32] &&
                         (pl_reg[k-1].dx >= $signed({2'b00, area_width_reg}));
                nx.yhi = !pl_reg[k-1].dy[32] &&
                         (pl_reg[k-1].dy >= $signed({2'b00, area_height_reg}));
                nx.rx  = 40'(pl_reg[k-1].dx[30:0]) * 40'(GRID_COLS);
                nx.ry  = 40'(pl_reg[k-1].dy[30:0]) * 40'(GRID_ROWS);
                nx.cx  = '0;
                nx.cy  = '0;
                if (asum > $signed({23'd0, ffps_pkg::Q360})) begin
                    nx.amode = ffps_pkg::AMODE_GT;
                    nx.am    = 48'(asum - 48'sd1);
                end else if (asum[47]) begin
                    nx.amode = ffps_pkg::AMODE_NEG;
                    nx.am    = 48'(-asum);
                end else begin
                    nx.amode = ffps_pkg::AMODE_IN;
                    nx.am    = 48'(asum);
                end
            end
            if (k >= 3 && k <= 10) begin
                // One quotient bit per stage
                if (pl_reg[k-1].rx >= dvx) begin
                    nx.rx     = pl_reg[k-1].rx - dvx;
                    nx.cx[DB] = 1'b1;
                end
                if (pl_reg[k-1].ry >= dvy) begin
                    nx.ry     = pl_reg[k-1].ry - dvy;
                    nx.cy[DB] = 1'b1;
                end
            end
            if (pl_reg[k-1].amode != ffps_pkg::AMODE_IN) begin
                // Reduce the angle magnitude modulo 360.0; an in-range sum is left alone
                if (k == 3) begin
                    nx.am = 48'({af1, pl_reg[k-1].am[18:0]});
                end
                if (k == 4) begin
                    nx.am = 48'({af2, pl_reg[k-1].am[18:0]});
                end
                if (k == 5) begin
                    nx.am = 48'({ar[5:0], pl_reg[k-1].am[18:0]});
                end
            end
            if (k == 12) begin
                // Steer toward the flow vector
                nx.flx = $signed(rd_data[31:0]);
                nx.fly = $signed(rd_data[63:32]);
                nx.prx = 65'(33'($signed(rd_data[31:0])) - 33'($signed(pl_reg[k-1].vx))) *
                         65'($signed({1'b0, pl_reg[k-1].dt}));
                nx.pry = 65'(33'($signed(rd_data[63:32])) - 33'($signed(pl_reg[k-1].vy))) *
                         65'($signed({1'b0, pl_reg[k-1].dt}));
            end
            if (k == 13) begin
                nx.nvx = ffps_pkg::sat32(50'($signed(pl_reg[k-1].vx)) +
                                         $signed(pl_reg[k-1].prx[65-1:16]) );
                nx.nvy = ffps_pkg::sat32(50'($signed(pl_reg[k-1].vy)) +
                                         $signed(pl_reg[k-1].pry[65-1:16]) );
            end
            if (k == 14) begin
                nx.prx = 65'($signed(pl_reg[k-1].nvx)) * 65'($signed({1'b0, pl_reg[k-1].dt}));
                nx.pry = 65'($signed(pl_reg[k-1].nvy)) * 65'($signed({1'b0, pl_reg[k-1].dt}));
            end
            if (k == 15) begin
                nx.sx = 50'($signed(pl_reg[k-1].px)) + $signed(pl_reg[k-1].prx[65-1:16]);
                nx.sy = 50'($signed(pl_reg[k-1].py)) + $signed(pl_reg[k-1].pry[65-1:16]);
            end
            if (k == 16) begin
                // Wrap once inside the area, then saturate
                if (pl_reg[k-1].sx > ex) begin
                    wx = pl_reg[k-1].sx - 50'($signed({1'b0, area_width_reg}));
                end else if (pl_reg[k-1].sx < 50'($signed(area_left_reg))) begin
                    wx = pl_reg[k-1].sx + 50'($signed({1'b0, area_width_reg}));
                end
                if (pl_reg[k-1].sy > ey) begin
                    wy = pl_reg[k-1].sy - 50'($signed({1'b0, area_height_reg}));
                end else if (pl_reg[k-1].sy < 50'($signed(area_top_reg))) begin
                    wy = pl_reg[k-1].sy + 50'($signed({1'b0, area_height_reg}));
                end
                nx.npx = ffps_pkg::sat32(wx);
                nx.npy = ffps_pkg::sat32(wy);
            end
            if (k == NS) begin
                // Finish the angle wrap
                case (pl_reg[k-1].amode)
                    ffps_pkg::AMODE_GT:  nx.am = pl_reg[k-1].am + 48'd1;
                    ffps_pkg::AMODE_NEG: nx.am = (pl_reg[k-1].am == 48'd0) ? 48'd0 :
                                                 48'(ffps_pkg::Q360) - pl_reg[k-1].am;
                    default:             nx.am = pl_reg[k-1].am;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pl_reg[k] <= nx;
            end
        end
    end

    // Table access at the end of stage 10: loads write, updates read.
    logic [7:0]                   col;
    logic [7:0]                   row;
    logic [16:0]                  lin;
    logic [ffps_pkg::TABLE_AW-1:0] raddr;
    logic                         mem_we;
    logic                         mem_re;

    always_comb begin
        if (pl_reg[10].xz || pl_reg[10].xlo) begin
            col = '0;
        end else if (pl_reg[10].xhi) begin
            col = 8'(GRID_COLS - 1);
        end else begin
            col = pl_reg[10].cx;
        end
        if (pl_reg[10].yz || pl_reg[10].ylo) begin
            row = '0;
        end else if (pl_reg[10].yhi) begin
            row = 8'(GRID_ROWS - 1);
        end else begin
            row = pl_reg[10].cy;
        end
        lin   = 17'(row) * 17'(GRID_COLS) + 17'(col);
        raddr = lin[ffps_pkg::TABLE_AW-1:0];
    end

    assign mem_we = en && pl_valid_reg[10] && pl_reg[10].load;
    assign mem_re = en && pl_valid_reg[10] && !pl_reg[10].load;

    ffps_flow_mem #(
        .DEPTH (ffps_pkg::TABLE_DEPTH),
        .AW    (ffps_pkg::TABLE_AW),
        .DW    (ffps_pkg::TABLE_DW)
    ) u_flow_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (pl_reg[10].cidx),
        .wdata ({pl_reg[10].fly, pl_reg[10].flx}),
        .re    (mem_re),
        .raddr (raddr),
        .rdata (rd_data)
    );

    // Output register: dead particles pass through unchanged.
    logic signed [31:0] life_live;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic signed [31:0] vx_reg;
    logic signed [31:0] vy_reg;
    logic [24:0]        ang_reg;
    logic signed [31:0] life_reg;
    logic               alive_reg;

    assign life_live = ffps_pkg::sat32(50'($signed(pl_reg[NS].life)) -
                                       50'($signed({1'b0, pl_reg[NS].dt})));

    // Load a new result when one arrives; otherwise hold until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && res_at_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && res_at_end) begin
            if (pl_reg[NS].dead) begin
                px_reg    <= pl_reg[NS].px;
                py_reg    <= pl_reg[NS].py;
                vx_reg    <= pl_reg[NS].vx;
                vy_reg    <= pl_reg[NS].vy;
                ang_reg   <= pl_reg[NS].ang;
                life_reg  <= pl_reg[NS].life;
                alive_reg <= (pl_reg[NS].life == 32'sd0);
            end else begin
                px_reg    <= pl_reg[NS].npx;
                py_reg    <= pl_reg[NS].npy;
                vx_reg    <= pl_reg[NS].nvx;
                vy_reg    <= pl_reg[NS].nvy;
                ang_reg   <= pl_reg[NS].am[24:0];
                life_reg  <= life_live;
                alive_reg <= !life_live[31];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_new_pos_x = px_reg;
    assign m_new_pos_y = py_reg;
    assign m_new_vel_x = vx_reg;
    assign m_new_vel_y = vy_reg;
    assign m_new_angle = ang_reg;
    assign m_new_life  = life_reg;
    assign m_alive     = alive_reg;

    // Checks
    a_alive_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (alive_reg == !life_reg[31]))
        else $error("alive flag disagrees with life sign");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("input held while output register empty");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(pl_valid_reg))
        else $error("pipeline moved during a stall");

    a_no_table_op_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |-> !mem_we && !mem_re)
        else $error("table accessed during a stall");

endmodule
